// ----- src/lied_pkg.sv -----
package lied_pkg;

  // Field widths of the stream payloads
  localparam int REQ_W  = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 5;
  localparam int LEN_W  = 5;
  localparam int MODE_W = 3;
  localparam int LIM_W  = 5;
  localparam int CFG_W  = 5;

  // Slave-side tdata is in_byte then read_index, padded to whole bytes
  localparam int S_TDATA_W = 16;
  // Master-side tdata is echo_valid, echo_byte, line_length, read_data
  localparam int M_TDATA_W = 24;

  // Request kinds carried on the slave-side tuser
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd1;

  // Configuration register indexes
  localparam logic CFG_INPUT_MODE   = 1'b0;
  localparam logic CFG_LENGTH_LIMIT = 1'b1;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_ANY     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEC     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DECA    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HECTO   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HEX     = 3'd4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ACTIVE = 2'd0,
    ST_DONE   = 2'd1,
    ST_CANCEL = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7f;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LF_HEX = 8'h66;
  localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;

endpackage

// ----- src/lied_ram.sv -----
module lied_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/line_input_editor_unit.sv -----
// Line input editor for bytes typed at a terminal.
// Beats enter on the s_ group: s_tuser is the request kind (start a line,
// typed byte, read a stored byte), s_tdata carries the byte and the read
// position. Every input beat produces exactly one result beat on the m_
// group: status on m_tuser, and echo, current length and read data on
// m_tdata. The configuration port sets the input mode and the length limit;
// the user must write it only while no beat is in flight; the block does
// not enforce it. The result beat follows acceptance in the next cycle.
// Unless the output stalls, a new beat is taken every cycle: classification,
// the state update and the line buffer write all happen at acceptance, and
// the buffer's registered read port delivers read data together with the result.
// Reset clears the active flag, the character count, the configuration and
// the output valid; the line buffer itself is not cleared, since only
// positions below the count are ever returned.
// When the receiver stalls, the result register holds its beat and s_tready
// drops until the beat is taken; a beat is accepted in the same cycle in
// which the waiting result leaves.
module line_input_editor_unit #(
  parameter int BUF_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [lied_pkg::CFG_W-1:0] cfg_wdata,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [lied_pkg::S_TDATA_W-1:0] s_tdata, // in_byte[7:0], read_index[12:8]
  input  logic [lied_pkg::REQ_W-1:0]     s_tuser, // req_type[1:0]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // echo_valid[0], echo_byte[8:1], line_length[13:9], read_data[21:14]
  output logic [lied_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [1:0]                     m_tuser  // status[1:0]
);

  localparam int CW   = $clog2(BUF_BYTES);
  localparam int CMPW = (CW > lied_pkg::IDX_W) ? CW : lied_pkg::IDX_W;

  // Configuration registers
  logic [lied_pkg::MODE_W-1:0] input_mode;
  logic [lied_pkg::LIM_W-1:0]  length_limit;

  // Editor state
  logic          active, active_next;
  logic [CW-1:0] char_count, char_count_next;

  // Result register
  logic                       out_valid;
  lied_pkg::status_t          out_status;
  logic                       out_echo_valid;
  logic [lied_pkg::BYTE_W-1:0] out_echo_byte;
  logic [lied_pkg::LEN_W-1:0] out_length;
  logic                       out_hit;

  // Combinational results for the beat at the input
  lied_pkg::status_t           status;
  logic                        echo_valid;
  logic [lied_pkg::BYTE_W-1:0] echo_byte;
  logic                        wr_en;
  logic                        rd_hit;
  logic                        s_accept;

  logic [lied_pkg::REQ_W-1:0]  req_type;
  logic [lied_pkg::BYTE_W-1:0] in_byte;
  logic [lied_pkg::IDX_W-1:0]  read_index;
  logic [CMPW-1:0]             count_ext, count_next_ext, limit_ext, idx_ext;
  logic                        is_digit, is_hex_letter, fits_mode, ok;
  logic [lied_pkg::BYTE_W-1:0] ram_q;

  assign req_type   = s_tuser;
  assign in_byte    = s_tdata[7:0];
  assign read_index = s_tdata[12:8];

  assign count_ext      = CMPW'(char_count);
  assign count_next_ext = CMPW'(char_count_next);
  assign limit_ext      = CMPW'(length_limit);
  assign idx_ext        = CMPW'(read_index);

  assign s_tready = !out_valid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      input_mode   <= lied_pkg::MODE_ANY;
      length_limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lied_pkg::CFG_INPUT_MODE:   input_mode   <= cfg_wdata[lied_pkg::MODE_W-1:0];
        lied_pkg::CFG_LENGTH_LIMIT: length_limit <= cfg_wdata[lied_pkg::LIM_W-1:0];
      endcase
    end
  end

  // Character classes, the input mode check and the length limit check
  always_comb begin
    is_digit      = (in_byte >= lied_pkg::CH_0) && (in_byte <= lied_pkg::CH_9);
    is_hex_letter = ((in_byte >= lied_pkg::CH_LA) && (in_byte <= lied_pkg::CH_LF_HEX)) ||
                    ((in_byte >= lied_pkg::CH_UA) && (in_byte <= lied_pkg::CH_UF));
    case (input_mode) inside
      lied_pkg::MODE_ANY: fits_mode = 1'b1;
      lied_pkg::MODE_DEC, lied_pkg::MODE_DECA, lied_pkg::MODE_HECTO: fits_mode = is_digit;
      lied_pkg::MODE_HEX: fits_mode = is_digit || is_hex_letter;
      default:            fits_mode = 1'b0;
    endcase
    ok = fits_mode && !((length_limit != '0) && (count_ext >= limit_ext));
  end

  // Edit decision for one beat
  always_comb begin
    active_next     = active;
    char_count_next = char_count;
    status          = active ? lied_pkg::ST_ACTIVE : lied_pkg::ST_IDLE;
    echo_valid      = 1'b0;
    echo_byte       = '0;
    wr_en           = 1'b0;
    rd_hit          = 1'b0;
    if (req_type == lied_pkg::REQ_START) begin
      active_next     = 1'b1;
      char_count_next = '0;
      status          = lied_pkg::ST_ACTIVE;
    end else if (req_type == lied_pkg::REQ_BYTE) begin
      if (active) begin
        if ((in_byte == lied_pkg::CH_CR) || (in_byte == lied_pkg::CH_LF)) begin
          active_next = 1'b0;
          status      = lied_pkg::ST_DONE;
        end else if ((in_byte == lied_pkg::CH_BS) || (in_byte == lied_pkg::CH_DEL)) begin
          if (char_count != '0) begin
            char_count_next = char_count - CW'(1);
            echo_valid      = 1'b1;
            echo_byte       = lied_pkg::CH_BS;
          end
        end else if ((in_byte < lied_pkg::CH_SPACE) || (in_byte > lied_pkg::CH_DEL)) begin
          active_next = 1'b0;
          status      = lied_pkg::ST_CANCEL;
        end else if (ok) begin
          echo_valid      = 1'b1;
          echo_byte       = in_byte;
          wr_en           = 1'b1;
          char_count_next = char_count + CW'(1);
          // The buffer keeps one spare position; reaching it ends the line
          if (count_ext == CMPW'(BUF_BYTES - 2)) begin
            active_next = 1'b0;
            status      = lied_pkg::ST_CANCEL;
          end
        end
      end
    end else begin
      rd_hit = idx_ext < count_ext;
    end
  end

  // Editor state update
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      char_count <= '0;
    end else if (s_accept) begin
      active     <= active_next;
      char_count <= char_count_next;
    end
  end

  // Line buffer: written at acceptance, read data arrives with the result
  lied_ram #(
    .WIDTH (lied_pkg::BYTE_W),
    .DEPTH (BUF_BYTES)
  ) u_line_ram (
    .clk   (clk),
    .we    (s_accept && wr_en),
    .waddr (char_count),
    .wdata (in_byte),
    .re    (s_accept),
    .raddr (idx_ext[CW-1:0]),
    .rdata (ram_q)
  );

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      out_status     <= status;
      out_echo_valid <= echo_valid;
      out_echo_byte  <= echo_byte;
      out_length     <= count_next_ext[lied_pkg::LEN_W-1:0];
      out_hit        <= rd_hit;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {2'b00,
                     (out_hit ? ram_q : 8'h00),
                     out_length,
                     out_echo_byte,
                     out_echo_valid};

endmodule

// ----- src/lied_checker.sv -----
module lied_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [lied_pkg::REQ_W-1:0]     s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [lied_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // No result beat is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat offered after reset");

  // A stalled result beat keeps its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result beat changed");

  // A start beat yields an active, empty line in the next cycle
  a_start_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == lied_pkg::REQ_START)) |=>
      (m_tvalid && (m_tuser == lied_pkg::ST_ACTIVE) && (m_tdata[13:9] == 5'd0)))
    else $error("start beat did not clear the line");

  // Typed bytes never return read data
  a_byte_no_read: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == lied_pkg::REQ_BYTE)) |=>
      (m_tdata[21:14] == 8'h00))
    else $error("read data on a typed byte result");

  // Without an echo the echo byte is zero
  a_echo_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == 8'h00))
    else $error("echo byte set without echo valid");

endmodule

bind line_input_editor_unit lied_checker u_lied_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
